// ===== design/lbbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbbc_pkg
// shared types and constants of the label bounding box collector
// ----------------------------------------------------------------------------
package lbbc_pkg;

    localparam int LABEL_W = 16;
    localparam int COORD_W = 12;
    localparam int SLOT_W  = 6;

    // labels at or above this value are not rooms
    localparam logic [LABEL_W-1:0] LABEL_LIMIT = 16'hFF00;

    // one pixel request
    typedef struct packed {
        logic [LABEL_W-1:0] pixel_label;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic               end_of_map;
    } t_pixel;

    // one room record
    typedef struct packed {
        logic               room_valid;
        logic [SLOT_W-1:0]  room_slot;
        logic [LABEL_W-1:0] room_label;
        logic [COORD_W-1:0] box_min_x;
        logic [COORD_W-1:0] box_max_x;
        logic [COORD_W-1:0] box_min_y;
        logic [COORD_W-1:0] box_max_y;
        logic               last_room;
        logic               slots_overflowed;
    } t_record;

    // pixel travelling down the chain of cells
    typedef struct packed {
        logic               vld;       // a pixel occupies this stage
        logic               room;      // room pixel not yet taken by a cell
        logic               eom;       // end of map marker
        logic [LABEL_W-1:0] label;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_bus;

    // contents of one slot cell
    typedef struct packed {
        logic               occ;
        logic [LABEL_W-1:0] label;
        logic [COORD_W-1:0] min_x;
        logic [COORD_W-1:0] max_x;
        logic [COORD_W-1:0] min_y;
        logic [COORD_W-1:0] max_y;
    } t_slot;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FLUSH,
        ST_DRAIN
    } t_state;

endpackage : lbbc_pkg
`default_nettype wire

// ===== design/lbbc_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbbc_cell
// one slot of the collector chain: claims a label, tracks its box
// ----------------------------------------------------------------------------
module lbbc_cell #(
    parameter int CW = 12
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  lbbc_pkg::t_bus       i_bus,
    input  lbbc_pkg::t_slot      i_next,
    input  wire                  i_shift,
    output lbbc_pkg::t_bus       o_bus,
    output lbbc_pkg::t_slot      o_slot
);

    localparam int CWO = lbbc_pkg::COORD_W;

    logic                          r_occ;
    logic [lbbc_pkg::LABEL_W-1:0]  r_label;
    logic [CW-1:0]                 r_min_x;
    logic [CW-1:0]                 r_max_x;
    logic [CW-1:0]                 r_min_y;
    logic [CW-1:0]                 r_max_y;
    logic                          r_vld;
    logic                          r_room;
    lbbc_pkg::t_bus                r_bus;

    logic          match;
    logic          claim;
    logic [CW-1:0] px;
    logic [CW-1:0] py;

    assign px    = i_bus.x[CW-1:0];
    assign py    = i_bus.y[CW-1:0];
    assign match = r_occ && i_bus.room && (i_bus.label == r_label);
    assign claim = !r_occ && i_bus.room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ  <= 1'b0;
            r_vld  <= 1'b0;
            r_room <= 1'b0;
        end else begin
            r_vld  <= i_bus.vld;
            r_room <= i_bus.room && !match && !claim;
            if (i_shift) begin
                r_occ <= i_next.occ;
            end else if (claim) begin
                r_occ <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bus <= i_bus;
        if (i_shift) begin
            r_label <= i_next.label;
            r_min_x <= i_next.min_x[CW-1:0];
            r_max_x <= i_next.max_x[CW-1:0];
            r_min_y <= i_next.min_y[CW-1:0];
            r_max_y <= i_next.max_y[CW-1:0];
        end else if (claim) begin
            r_label <= i_bus.label;
            r_min_x <= px;
            r_max_x <= px;
            r_min_y <= py;
            r_max_y <= py;
        end else if (match) begin
            if (px < r_min_x) r_min_x <= px;
            if (px > r_max_x) r_max_x <= px;
            if (py < r_min_y) r_min_y <= py;
            if (py > r_max_y) r_max_y <= py;
        end
    end

    always_comb begin
        o_bus        = r_bus;
        o_bus.vld    = r_vld;
        o_bus.room   = r_room;
        o_slot.occ   = r_occ;
        o_slot.label = r_label;
        o_slot.min_x = CWO'(r_min_x);
        o_slot.max_x = CWO'(r_max_x);
        o_slot.min_y = CWO'(r_min_y);
        o_slot.max_y = CWO'(r_max_y);
    end

    // slots fill from the head, so an occupied neighbor implies this one is taken
    a_contiguous : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_next.occ |-> r_occ)
        else $error("slot occupancy not contiguous");

    a_room_implies_vld : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_bus.room |-> o_bus.vld)
        else $error("room pixel without a valid stage");

    a_no_claim_on_shift : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_shift |-> !i_bus.vld)
        else $error("pixel in flight while records drain");

endmodule : lbbc_cell
`default_nettype wire

// ===== design/label_bounding_box_collector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// label_bounding_box_collector
// collects per-label bounding boxes of a labeled map and lists them per map
// ----------------------------------------------------------------------------
//  channel  dir  handshake                  payload
//  pixel    in   i_pix_valid / o_pix_stall  i_pix (lbbc_pkg::t_pixel)
//  record   out  o_rec_valid / i_rec_stall  o_rec (lbbc_pkg::t_record)
//
//  pixels enter at one per cycle while a map streams in
//  the end-of-map pixel crosses the whole cell chain,
//  then records leave at one per cycle unless stalled, one per room (one for an empty map)
//  the pixel side stalls from the end-of-map pixel until the last record goes
//  reset (synchronous, active low) empties every slot
//  a stalled record holds; the cell chain only shifts on an accepted record
// ----------------------------------------------------------------------------
module label_bounding_box_collector #(
    parameter int MAX_ROOMS  = 64,
    parameter int COORD_BITS = 12
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_pix_valid,
    output logic                  o_pix_stall,
    input  lbbc_pkg::t_pixel      i_pix,
    output logic                  o_rec_valid,
    input  wire                   i_rec_stall,
    output lbbc_pkg::t_record     o_rec
);

    // stored coordinate width: the pixel fields carry at most COORD_W bits
    localparam int CW = (COORD_BITS < lbbc_pkg::COORD_W) ? COORD_BITS : lbbc_pkg::COORD_W;

    lbbc_pkg::t_state  r_state;
    lbbc_pkg::t_state  n_state;
    logic              r_ovf;
    logic              n_ovf;
    logic [lbbc_pkg::SLOT_W-1:0] r_slot;
    logic [lbbc_pkg::SLOT_W-1:0] n_slot;

    lbbc_pkg::t_bus    bus [0:MAX_ROOMS];
    lbbc_pkg::t_slot   rec [0:MAX_ROOMS];

    logic pix_acc;
    logic rec_acc;
    logic is_room;
    logic shift;

    // pixel request accepted only while a map streams in
    assign pix_acc = i_pix_valid && !o_pix_stall;
    assign rec_acc = o_rec_valid && !i_rec_stall;
    assign is_room = (i_pix.pixel_label != '0) && (i_pix.pixel_label < lbbc_pkg::LABEL_LIMIT);

    // head of the chain
    always_comb begin
        bus[0].vld   = pix_acc;
        bus[0].room  = pix_acc && is_room;
        bus[0].eom   = i_pix.end_of_map;
        bus[0].label = i_pix.pixel_label;
        bus[0].x     = i_pix.pixel_x;
        bus[0].y     = i_pix.pixel_y;
    end

    // past the tail there is nothing to shift in
    assign rec[MAX_ROOMS] = '0;

    // a drained record leaves cell 0, all cells move one place toward the head
    assign shift = rec_acc;

    for (genvar g = 0; g < MAX_ROOMS; g++) begin : g_cell
        lbbc_cell #(
            .CW (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (bus[g]),
            .i_next  (rec[g+1]),
            .i_shift (shift),
            .o_bus   (bus[g+1]),
            .o_slot  (rec[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lbbc_pkg::ST_RUN;
            r_ovf   <= 1'b0;
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            r_ovf   <= n_ovf;
            r_slot  <= n_slot;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ovf       = r_ovf;
        n_slot      = r_slot;
        o_pix_stall = 1'b1;
        o_rec_valid = 1'b0;

        // room pixel that fell off the tail found every slot taken
        if (bus[MAX_ROOMS].vld && bus[MAX_ROOMS].room) begin
            n_ovf = 1'b1;
        end

        case (r_state)
            lbbc_pkg::ST_RUN: begin
                o_pix_stall = 1'b0;
                if (pix_acc && i_pix.end_of_map) begin
                    n_state = lbbc_pkg::ST_FLUSH;
                end
            end
            lbbc_pkg::ST_FLUSH: begin
                // wait for the end marker to pass every cell
                if (bus[MAX_ROOMS].vld && bus[MAX_ROOMS].eom) begin
                    n_state = lbbc_pkg::ST_DRAIN;
                end
            end
            lbbc_pkg::ST_DRAIN: begin
                o_rec_valid = 1'b1;
                if (rec_acc) begin
                    n_slot = r_slot + 1'b1;
                    if (o_rec.last_room) begin
                        n_state = lbbc_pkg::ST_RUN;
                        n_ovf   = 1'b0;
                        n_slot  = '0;
                    end
                end
            end
            default: begin
                n_state = lbbc_pkg::ST_RUN;
            end
        endcase
    end

    // record always comes from cell 0; an empty map gives one invalid record
    always_comb begin
        o_rec                  = '0;
        o_rec.slots_overflowed = r_ovf;
        if (rec[0].occ) begin
            o_rec.room_valid = 1'b1;
            o_rec.room_slot  = r_slot;
            o_rec.room_label = rec[0].label;
            o_rec.box_min_x  = rec[0].min_x;
            o_rec.box_max_x  = rec[0].max_x;
            o_rec.box_min_y  = rec[0].min_y;
            o_rec.box_max_y  = rec[0].max_y;
            o_rec.last_room  = !rec[1].occ;
        end else begin
            o_rec.last_room  = 1'b1;
        end
    end

    a_end_starts_flush : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pix_acc && i_pix.end_of_map) |=> (r_state == lbbc_pkg::ST_FLUSH))
        else $error("end of map did not start the flush");

    a_drain_chain_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lbbc_pkg::ST_DRAIN) |-> !bus[MAX_ROOMS].vld)
        else $error("pixel left the chain while records drain");

    a_last_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rec_acc && o_rec.last_room) |=> (!rec[0].occ && !r_ovf && (r_slot == '0)))
        else $error("collector not cleared after the last record");

    a_flush_no_records : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lbbc_pkg::ST_FLUSH) |-> (!o_rec_valid && o_pix_stall))
        else $error("handshake active during flush");

endmodule : label_bounding_box_collector
`default_nettype wire

// ===== tb/sv/label_bounding_box_collector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// label_bounding_box_collector_tb
// streams labeled maps into the collector and checks every room record
// against a behavioral box tracker kept in step with the accepted pixels
// ----------------------------------------------------------------------------
module label_bounding_box_collector_tb;

    localparam int ROOM_SLOTS   = 64;
    localparam int ROOM_TARGET  = 370;      // pixel requests to queue at least, over the whole run
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int QUIET_DEPTH  = 40;       // no idling once this few requests remain
    localparam int LONG_HOLD    = 400;      // receiver hold-off, well past the chain length
    localparam int HOLD_AT_REC  = 30;

    logic              i_clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              pix_valid = 1'b0;
    lbbc_pkg::t_pixel  pix_req = '0;
    logic              rec_stall = 1'b0;
    logic              o_pix_stall;
    logic              o_rec_valid;
    lbbc_pkg::t_record o_rec;

    // pixel requests waiting to be offered, filled up front
    lbbc_pkg::t_pixel  pending[$];
    // records the box tracker says must come out, oldest first
    lbbc_pkg::t_record room_records_due[$];

    // box tracker state
    logic [lbbc_pkg::LABEL_W-1:0] box_label[ROOM_SLOTS];
    logic [lbbc_pkg::COORD_W-1:0] box_min_x[ROOM_SLOTS];
    logic [lbbc_pkg::COORD_W-1:0] box_max_x[ROOM_SLOTS];
    logic [lbbc_pkg::COORD_W-1:0] box_min_y[ROOM_SLOTS];
    logic [lbbc_pkg::COORD_W-1:0] box_max_y[ROOM_SLOTS];
    int                 rooms_used = 0;
    logic               rooms_overflowed = 1'b0;

    int   room_items = 0;
    int   error_count = 0;
    int   records_checked = 0;
    int   cycle_count = 0;
    int   gap_left = 0;
    int   stall_left = 0;
    logic quiet = 1'b0;
    logic long_hold_done = 1'b0;

    label_bounding_box_collector #(
        .MAX_ROOMS  (ROOM_SLOTS),
        .COORD_BITS (lbbc_pkg::COORD_W)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_pix_valid (pix_valid),
        .o_pix_stall (o_pix_stall),
        .i_pix       (pix_req),
        .o_rec_valid (o_rec_valid),
        .i_rec_stall (rec_stall),
        .o_rec       (o_rec)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // runaway guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic is_room(input logic [lbbc_pkg::LABEL_W-1:0] lbl);
        return (lbl != '0) && (lbl < lbbc_pkg::LABEL_LIMIT);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at record %0d: %s got 0x%0h expected 0x%0h",
                 records_checked, what, got, want);
        error_count++;
    endtask

    // queue one pixel request; every request counts toward the target
    task automatic add_pixel(input logic [lbbc_pkg::LABEL_W-1:0] lbl,
                             input logic [lbbc_pkg::COORD_W-1:0] x,
                             input logic [lbbc_pkg::COORD_W-1:0] y, input logic eom);
        lbbc_pkg::t_pixel p;
        p.pixel_label = lbl;
        p.pixel_x     = x;
        p.pixel_y     = y;
        p.end_of_map  = eom;
        pending = {pending, p};
        room_items++;
    endtask

    function automatic logic [lbbc_pkg::LABEL_W-1:0] noise_label();
        if ($urandom_range(0, 2) == 0)
            return '0;
        return lbbc_pkg::LABEL_W'($urandom_range(32'(lbbc_pkg::LABEL_LIMIT), 16'hFFFF));
    endfunction

    // map with many distinct labels; more than ROOM_SLOTS of them overflows
    // late pixels revisit older labels so owned slots keep growing while full
    task automatic add_crowded_map(input int n_labels);
        logic [lbbc_pkg::LABEL_W-1:0] lbls[70];
        int k;
        for (k = 0; k < n_labels; k++)
            lbls[k] = lbbc_pkg::LABEL_W'(k * 900 + $urandom_range(1, 899));
        for (k = 0; k < n_labels; k++) begin
            if (k >= ROOM_SLOTS - 8)
                add_pixel(lbls[$urandom_range(0, k - 1)], lbbc_pkg::COORD_W'($urandom),
                          lbbc_pkg::COORD_W'($urandom), 1'b0);
            add_pixel(lbls[k], lbbc_pkg::COORD_W'($urandom), lbbc_pkg::COORD_W'($urandom),
                      k == n_labels - 1);
        end
    endtask

    // box tracker: fold one accepted pixel in, list the records at end of map
    task automatic track_pixel(input lbbc_pkg::t_pixel p);
        lbbc_pkg::t_record r;
        logic    hit;
        int      i;
        hit = 1'b0;
        if (is_room(p.pixel_label)) begin
            for (i = 0; i < rooms_used; i++) begin
                if (!hit && box_label[i] == p.pixel_label) begin
                    hit = 1'b1;
                    if (p.pixel_x < box_min_x[i]) box_min_x[i] = p.pixel_x;
                    if (p.pixel_x > box_max_x[i]) box_max_x[i] = p.pixel_x;
                    if (p.pixel_y < box_min_y[i]) box_min_y[i] = p.pixel_y;
                    if (p.pixel_y > box_max_y[i]) box_max_y[i] = p.pixel_y;
                end
            end
            if (!hit) begin
                if (rooms_used < ROOM_SLOTS) begin
                    box_label[rooms_used] = p.pixel_label;
                    box_min_x[rooms_used] = p.pixel_x;
                    box_max_x[rooms_used] = p.pixel_x;
                    box_min_y[rooms_used] = p.pixel_y;
                    box_max_y[rooms_used] = p.pixel_y;
                    rooms_used++;
                end else begin
                    rooms_overflowed = 1'b1;
                end
            end
        end
        if (p.end_of_map) begin
            if (rooms_used == 0) begin
                // map without rooms: a single invalid record
                r = '0;
                r.last_room        = 1'b1;
                r.slots_overflowed = rooms_overflowed;
                room_records_due = {room_records_due, r};
            end
            for (i = 0; i < rooms_used; i++) begin
                r.room_valid       = 1'b1;
                r.room_slot        = lbbc_pkg::SLOT_W'(i);
                r.room_label       = box_label[i];
                r.box_min_x        = box_min_x[i];
                r.box_max_x        = box_max_x[i];
                r.box_min_y        = box_min_y[i];
                r.box_max_y        = box_max_y[i];
                r.last_room        = (i == rooms_used - 1);
                r.slots_overflowed = rooms_overflowed;
                room_records_due = {room_records_due, r};
            end
            rooms_used       = 0;
            rooms_overflowed = 1'b0;
        end
    endtask

    // pixel driver: offers requests from the pending queue, idles in random bursts
    always @(posedge i_clk) begin
        if (!rst_n) begin
            pix_valid <= 1'b0;
            gap_left  <= 0;
        end else begin
            if (pix_valid && !o_pix_stall)
                track_pixel(pix_req);
            // the payload may only change once the current request is taken
            if (!pix_valid || !o_pix_stall) begin
                if (gap_left != 0) begin
                    pix_valid <= 1'b0;
                    gap_left  <= gap_left - 1;
                end else if (pending.size() != 0) begin
                    if (pending.size() > QUIET_DEPTH && $urandom_range(0, 9) == 0) begin
                        pix_valid <= 1'b0;
                        gap_left  <= $urandom_range(0, 14);
                    end else begin
                        pix_valid <= 1'b1;
                        pix_req   <= pending.pop_front();
                    end
                end else begin
                    pix_valid <= 1'b0;
                end
            end
            quiet <= (pending.size() <= QUIET_DEPTH);
        end
    end

    // record receiver stall: one long hold-off, then random bursts
    always @(posedge i_clk) begin
        if (!rst_n) begin
            rec_stall      <= 1'b0;
            stall_left     <= 0;
            long_hold_done <= 1'b0;
        end else if (!long_hold_done && records_checked >= HOLD_AT_REC) begin
            // pixels keep being offered while records back up and the input stalls
            rec_stall      <= 1'b1;
            stall_left     <= LONG_HOLD;
            long_hold_done <= 1'b1;
        end else if (stall_left != 0) begin
            rec_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rec_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 14);
        end else begin
            rec_stall <= 1'b0;
        end
    end

    // record monitor: every accepted record against the oldest expectation
    always @(posedge i_clk) begin : rec_monitor
        lbbc_pkg::t_record want;
        if (rst_n && o_rec_valid && !rec_stall) begin
            records_checked <= records_checked + 1;
            if (room_records_due.size() == 0) begin
                report_mismatch("unexpected record, slot", 32'(o_rec.room_slot), '0);
            end else begin
                want = room_records_due.pop_front();
                if (o_rec.room_valid !== want.room_valid)
                    report_mismatch("room_valid", 32'(o_rec.room_valid), 32'(want.room_valid));
                if (o_rec.room_slot !== want.room_slot)
                    report_mismatch("room_slot", 32'(o_rec.room_slot), 32'(want.room_slot));
                if (o_rec.room_label !== want.room_label)
                    report_mismatch("room_label", 32'(o_rec.room_label), 32'(want.room_label));
                if (o_rec.box_min_x !== want.box_min_x)
                    report_mismatch("box_min_x", 32'(o_rec.box_min_x), 32'(want.box_min_x));
                if (o_rec.box_max_x !== want.box_max_x)
                    report_mismatch("box_max_x", 32'(o_rec.box_max_x), 32'(want.box_max_x));
                if (o_rec.box_min_y !== want.box_min_y)
                    report_mismatch("box_min_y", 32'(o_rec.box_min_y), 32'(want.box_min_y));
                if (o_rec.box_max_y !== want.box_max_y)
                    report_mismatch("box_max_y", 32'(o_rec.box_max_y), 32'(want.box_max_y));
                if (o_rec.last_room !== want.last_room)
                    report_mismatch("last_room", 32'(o_rec.last_room), 32'(want.last_room));
                if (o_rec.slots_overflowed !== want.slots_overflowed)
                    report_mismatch("slots_overflowed", 32'(o_rec.slots_overflowed),
                                    32'(want.slots_overflowed));
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        logic [lbbc_pkg::LABEL_W-1:0] pool[8];
        lbbc_pkg::t_record miss;
        int pool_n;
        int map_len;
        int j;
        int drain;
        logic crowd_done;
        logic full_done;

        crowd_done = 1'b0;
        full_done  = 1'b0;

        // empty maps closed by non-room labels at both ends of the range
        add_pixel('0, '0, '0, 1'b1);
        add_pixel(16'hFFFF, 12'hFFF, 12'hFFF, 1'b1);
        add_pixel(lbbc_pkg::LABEL_LIMIT, 12'h800, 12'h001, 1'b1);
        // single room carried by the end-of-map pixel itself
        add_pixel(16'h0001, '0, '0, 1'b1);
        // highest room label, coordinate extremes, noise between, existing label at end
        add_pixel(16'hFEFF, 12'hFFF, 12'hFFF, 1'b0);
        add_pixel(16'hFEFF, '0, '0, 1'b0);
        add_pixel(16'h0001, 12'h800, 12'h007, 1'b0);
        add_pixel(lbbc_pkg::LABEL_LIMIT, 12'h123, 12'h456, 1'b0);
        add_pixel('0, 12'hFFF, '0, 1'b0);
        add_pixel(16'h0001, 12'hFFF, '0, 1'b1);
        // alternating bit patterns, closed by a non-room pixel
        add_pixel(16'h5555, 12'h001, 12'h002, 1'b0);
        add_pixel(16'hAAAA, 12'hFFE, 12'hFFD, 1'b0);
        add_pixel(16'h5555, 12'h555, 12'hAAA, 1'b0);
        add_pixel(16'hFFFE, 12'h000, 12'hFFF, 1'b0);
        add_pixel('0, 12'hFFF, 12'hFFF, 1'b1);
        // only noise, then an empty-map record
        add_pixel(16'hFF80, 12'h0AA, 12'h055, 1'b0);
        add_pixel('0, 12'h3C3, 12'hC3C, 1'b0);
        add_pixel(16'hFF01, 12'h000, 12'h000, 1'b1);

        while (room_items < ROOM_TARGET) begin
            if (!crowd_done && room_items >= 100) begin
                crowd_done = 1'b1;
                add_crowded_map(ROOM_SLOTS + 6);
            end else if (!full_done && room_items >= 220) begin
                full_done = 1'b1;
                add_crowded_map(ROOM_SLOTS);
            end else if ($urandom_range(0, 11) == 0) begin
                map_len = $urandom_range(0, 4);
                for (j = 0; j < map_len; j++)
                    add_pixel(noise_label(), lbbc_pkg::COORD_W'($urandom),
                              lbbc_pkg::COORD_W'($urandom), 1'b0);
                add_pixel(noise_label(), lbbc_pkg::COORD_W'($urandom),
                          lbbc_pkg::COORD_W'($urandom), 1'b1);
            end else begin
                // ordinary map: a few rooms revisited, some noise pixels
                pool_n = $urandom_range(1, 8);
                for (j = 0; j < pool_n; j++)
                    pool[j] = lbbc_pkg::LABEL_W'($urandom_range(1,
                                  32'(lbbc_pkg::LABEL_LIMIT) - 1));
                map_len = $urandom_range(1, 20);
                for (j = 0; j < map_len; j++) begin
                    if ($urandom_range(0, 5) == 0)
                        add_pixel(noise_label(), lbbc_pkg::COORD_W'($urandom),
                                  lbbc_pkg::COORD_W'($urandom), j == map_len - 1);
                    else
                        add_pixel(pool[$urandom_range(0, pool_n - 1)],
                                  lbbc_pkg::COORD_W'($urandom),
                                  lbbc_pkg::COORD_W'($urandom), j == map_len - 1);
                end
            end
        end

        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;

        // every request accepted, then every record back, then a quiet tail
        do @(negedge i_clk); while (pending.size() != 0 || pix_valid);
        drain = 0;
        while (room_records_due.size() != 0 && drain < DRAIN_LIMIT) begin
            @(negedge i_clk);
            drain++;
        end
        repeat (ROOM_SLOTS + 40) @(negedge i_clk);
        while (room_records_due.size() != 0) begin
            miss = room_records_due.pop_front();
            report_mismatch("missing record, slot", '0, 32'(miss.room_slot));
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
design/lbbc_pkg.sv
design/lbbc_cell.sv
design/label_bounding_box_collector.sv
tb/sv/label_bounding_box_collector_tb.sv
